FILE: sv/csp_pkg.sv
package csp_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CtxW    = 6;
  localparam int unsigned SelW    = 4;
  // Signed width of a weighted sum: 8A + B + 4 stays below 2^20.
  localparam int unsigned NumW    = 21;

  // Division by three is a multiply by ceil(2^20 / 3) and a shift by 20.
  // It is exact for numerators below 2^19. The one predictor that divides
  // by three never exceeds 3 * 65535 + 1.
  localparam int unsigned Div3InW  = 18;
  localparam int unsigned RecipW   = 19;
  localparam int unsigned Div3Sh   = 20;
  localparam logic [RecipW-1:0] Recip3 = 19'd349526;
  localparam int unsigned Q3W      = Div3InW + RecipW - Div3Sh;

  localparam logic [SelW-1:0] PredMed = 4'd15;

  localparam int unsigned CfgAddrW = 3;
  localparam logic RegClipLow  = 1'b0;
  localparam logic RegClipHigh = 1'b1;

  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_4,
    DIV_8
  } div_e;

  // Stage 1: predictor picked from the table and masked neighbors.
  typedef struct packed {
    logic [SelW-1:0]    sel;
    logic [SampleW-1:0] a;
    logic [SampleW-1:0] b;
    logic [SampleW-1:0] c;
    logic [SampleW-1:0] d;
  } s1_t;

  // Stage 2: numerator before the division.
  typedef struct packed {
    logic [SelW-1:0]        sel;
    div_e                   div;
    logic signed [NumW-1:0] num;
  } s2_t;

  // Stage 3: quotient from the shift path and from the divide-by-three path.
  typedef struct packed {
    logic [SelW-1:0]        sel;
    logic                   div3;
    logic signed [NumW-1:0] quot;
    logic [Q3W-1:0]         q3;
  } s3_t;

  function automatic div_e pred_div(input logic [SelW-1:0] sel);
    div_e dv;
    case (sel)
      4'd0, 4'd1, 4'd9, PredMed: dv = DIV_1;
      4'd3:                      dv = DIV_3;
      4'd11, 4'd14:              dv = DIV_4;
      4'd7, 4'd8, 4'd12:         dv = DIV_8;
      default:                   dv = DIV_2;
    endcase
    return dv;
  endfunction

endpackage

FILE: sv/context_selected_pixel_predictor_core.sv
// Context-selected pixel predictor. Each input beat either loads a table
// entry (tuser = 0) that maps a context number to one of sixteen fixed
// predictors, or asks for a prediction (tuser = 1) from the causal neighbors
// A to D of one pixel; neighbors E and F are carried but never weighted.
// Load beats give no output beat; each prediction beat gives exactly one,
// in order. The block takes one beat per clock cycle while it is not held
// by a stalled output, and a prediction appears in the last of four
// register stages: a registered table read taken at the accepting edge,
// the weighted sum or median edge detector, the division (shifts, or one
// 18 x 19 multiply for the divide-by-three predictor), and the clip into
// the output register. Each stage holds only while its successor is full
// and stalled, so bubbles close up and a waiting output beat does not stop
// the input until the pipeline is full. The table is a 64-entry memory with
// a valid flag per entry that reset clears at once, so no clearing pass is
// needed and an entry never loaded reads as predictor 0. A load followed in
// the next cycle by a prediction for the same context already sees the new
// entry. The clip bounds sit behind an APB port at byte addresses 0 (low)
// and 4 (high) and are only to be written while no prediction is in flight.
module context_selected_pixel_predictor_core import csp_pkg::*; #(
  parameter int unsigned CONTEXTS    = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: context_req[5:0], predictor_load[9:6], neighbor_a[25:10],
  // neighbor_b[41:26], neighbor_c[57:42], neighbor_d[73:58],
  // neighbor_e[89:74], neighbor_f[105:90], zero padding up to bit 111.
  input  logic [111:0]        s_axis_tdata,
  // tuser: mode[0] (0 loads a table entry, 1 asks for a prediction).
  input  logic [0:0]          s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: prediction[15:0], predictor_used[19:16], zero padding to bit 23.
  output logic [23:0]         m_axis_tdata,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Samples wider than SAMPLE_BITS are reduced to their low bits.
  localparam logic [SampleW-1:0] SampleMask =
    SampleW'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [SampleW-1:0] clip_low_q, clip_high_q;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic               en1, en2, en3, en4;
  logic               in_accept, is_predict, cfg_wr;
  logic [CtxW-1:0]    ctx;
  logic [SelW-1:0]    sel_wr;
  logic [SampleW-1:0] na, nb, nc, nd;
  s1_t                s1;
  s2_t                s2;
  s3_t                s3;
  logic [SampleW-1:0] prediction;
  logic [SelW-1:0]    predictor_used;

  // Unpack the input beat. Neighbors E and F are not used by any predictor.
  assign ctx    = s_axis_tdata[5:0];
  assign sel_wr = s_axis_tdata[9:6];
  assign na     = s_axis_tdata[25:10] & SampleMask;
  assign nb     = s_axis_tdata[41:26] & SampleMask;
  assign nc     = s_axis_tdata[57:42] & SampleMask;
  assign nd     = s_axis_tdata[73:58] & SampleMask;

  // A stage may load when it is empty or its contents move on this cycle.
  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign is_predict    = s_axis_tuser[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_accept && is_predict;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  csp_table #(
    .CONTEXTS (CONTEXTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_en_i (en1),
    .wr_en_i   (in_accept && !is_predict),
    .ctx_i     (ctx),
    .sel_wr_i  (sel_wr),
    .a_i       (na),
    .b_i       (nb),
    .c_i       (nc),
    .d_i       (nd),
    .s1_o      (s1)
  );

  csp_form u_form (
    .clk_i (clk_i),
    .en_i  (en2),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  csp_divide u_divide (
    .clk_i (clk_i),
    .en_i  (en3),
    .s2_i  (s2),
    .s3_o  (s3)
  );

  csp_clip u_clip (
    .clk_i            (clk_i),
    .en_i             (en4),
    .s3_i             (s3),
    .clip_low_i       (clip_low_q),
    .clip_high_i      (clip_high_q),
    .prediction_o     (prediction),
    .predictor_used_o (predictor_used)
  );

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {4'b0000, predictor_used, prediction};

  // Configuration registers. Bit 2 of the address selects the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_low_q  <= 16'd0;
      clip_high_q <= 16'd255;
    end else if (cfg_wr) begin
      if (paddr[2] == RegClipLow) begin
        clip_low_q <= pwdata[SampleW-1:0];
      end else begin
        clip_high_q <= pwdata[SampleW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegClipHigh) ? {16'd0, clip_high_q} : {16'd0, clip_low_q};

endmodule

FILE: sv/csp_table.sv
module csp_table import csp_pkg::*; #(
  parameter int unsigned CONTEXTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_en_i,
  input  logic               wr_en_i,
  input  logic [CtxW-1:0]    ctx_i,
  input  logic [SelW-1:0]    sel_wr_i,
  input  logic [SampleW-1:0] a_i,
  input  logic [SampleW-1:0] b_i,
  input  logic [SampleW-1:0] c_i,
  input  logic [SampleW-1:0] d_i,
  output s1_t                s1_o
);

  // Only the first 64 contexts can be addressed by the six-bit context field.
  localparam int unsigned Depth = (CONTEXTS < (1 << CtxW)) ? CONTEXTS : (1 << CtxW);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [SelW-1:0]    mem [Depth];
  logic [Depth-1:0]   vld_q;
  logic [SelW-1:0]    rd_q;
  logic               hit_q;
  logic [SampleW-1:0] a_q, b_q, c_q, d_q;
  logic [IdxW-1:0]    idx;
  logic               in_range;

  assign idx      = ctx_i[IdxW-1:0];
  assign in_range = 32'(ctx_i) < CONTEXTS;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_range) begin
      mem[idx] <= sel_wr_i;
    end
  end

  // An entry that was never written reads as predictor 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i && in_range) begin
      vld_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      rd_q  <= mem[idx];
      hit_q <= in_range && vld_q[idx];
      a_q   <= a_i;
      b_q   <= b_i;
      c_q   <= c_i;
      d_q   <= d_i;
    end
  end

  assign s1_o.sel = hit_q ? rd_q : '0;
  assign s1_o.a   = a_q;
  assign s1_o.b   = b_q;
  assign s1_o.c   = c_q;
  assign s1_o.d   = d_q;

endmodule

FILE: sv/csp_form.sv
module csp_form import csp_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  s1_t  s1_i,
  output s2_t  s2_o
);

  logic signed [NumW-1:0] sa, sb, sc, sd;
  logic signed [NumW-1:0] med;
  logic signed [NumW-1:0] num;
  logic [SampleW-1:0]     hi, lo;
  s2_t                    s2_q;

  assign sa = $signed({{(NumW-SampleW){1'b0}}, s1_i.a});
  assign sb = $signed({{(NumW-SampleW){1'b0}}, s1_i.b});
  assign sc = $signed({{(NumW-SampleW){1'b0}}, s1_i.c});
  assign sd = $signed({{(NumW-SampleW){1'b0}}, s1_i.d});

  // Median edge detector: pick the smaller neighbor on a rising edge above,
  // the larger on a falling edge, the planar estimate otherwise.
  always_comb begin
    hi = (s1_i.a > s1_i.b) ? s1_i.a : s1_i.b;
    lo = (s1_i.a > s1_i.b) ? s1_i.b : s1_i.a;
    if (s1_i.c >= hi) begin
      med = $signed({{(NumW-SampleW){1'b0}}, lo});
    end else if (s1_i.c <= lo) begin
      med = $signed({{(NumW-SampleW){1'b0}}, hi});
    end else begin
      med = sa + sb - sc;
    end
  end

  always_comb begin
    case (s1_i.sel)
      4'd0:    num = sa;
      4'd1:    num = sb;
      4'd2:    num = sa + sb;
      4'd3:    num = sa + sb + sc + 21'sd1;
      4'd4:    num = sa + sc;
      4'd5:    num = sa + sd;
      4'd6:    num = sb + sc;
      4'd7:    num = (sa <<< 2) + (sb <<< 2) - sc + sd + 21'sd4;
      4'd8:    num = (sa <<< 2) + (sb <<< 2) + sc - sd + 21'sd4;
      4'd9:    num = sa + sb - sc;
      4'd10:   num = (sa <<< 1) + sb - sc + 21'sd1;
      4'd11:   num = (sa <<< 2) + sb - sc + 21'sd2;
      4'd12:   num = (sa <<< 3) + sb - sc + 21'sd4;
      4'd13:   num = sa + (sb <<< 1) - sc + 21'sd1;
      4'd14:   num = sa + (sb <<< 2) - sc + 21'sd2;
      default: num = med;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q.sel <= s1_i.sel;
      s2_q.div <= pred_div(s1_i.sel);
      s2_q.num <= num;
    end
  end

  assign s2_o = s2_q;

endmodule

FILE: sv/csp_divide.sv
module csp_divide import csp_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  s2_t  s2_i,
  output s3_t  s3_o
);

  logic signed [NumW-1:0]        quot;
  logic [Div3InW+RecipW-1:0]     prod;
  s3_t                           s3_q;

  // Shifts truncate toward zero: a negative numerator is biased by the
  // divisor minus one before the arithmetic shift.
  always_comb begin
    case (s2_i.div)
      DIV_2:   quot = (s2_i.num + (s2_i.num[NumW-1] ? 21'sd1 : 21'sd0)) >>> 1;
      DIV_4:   quot = (s2_i.num + (s2_i.num[NumW-1] ? 21'sd3 : 21'sd0)) >>> 2;
      DIV_8:   quot = (s2_i.num + (s2_i.num[NumW-1] ? 21'sd7 : 21'sd0)) >>> 3;
      default: quot = s2_i.num;
    endcase
  end

  assign prod = s2_i.num[Div3InW-1:0] * Recip3;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q.sel  <= s2_i.sel;
      s3_q.div3 <= (s2_i.div == DIV_3);
      s3_q.quot <= quot;
      s3_q.q3   <= prod[Div3InW+RecipW-1:Div3Sh];
    end
  end

  assign s3_o = s3_q;

endmodule

FILE: sv/csp_clip.sv
module csp_clip import csp_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  s3_t                s3_i,
  input  logic [SampleW-1:0] clip_low_i,
  input  logic [SampleW-1:0] clip_high_i,
  output logic [SampleW-1:0] prediction_o,
  output logic [SelW-1:0]    predictor_used_o
);

  logic signed [NumW-1:0] q, lo, hi;
  logic [SampleW-1:0]     clipped;
  logic [SampleW-1:0]     pred_q;
  logic [SelW-1:0]        sel_q;

  assign q  = s3_i.div3 ? $signed({{(NumW-Q3W){1'b0}}, s3_i.q3}) : s3_i.quot;
  assign lo = $signed({{(NumW-SampleW){1'b0}}, clip_low_i});
  assign hi = $signed({{(NumW-SampleW){1'b0}}, clip_high_i});

  // The low bound is tested first, so with an inverted range it wins only
  // for values below it.
  always_comb begin
    if (q < lo) begin
      clipped = clip_low_i;
    end else if (q > hi) begin
      clipped = clip_high_i;
    end else begin
      clipped = q[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pred_q <= clipped;
      sel_q  <= s3_i.sel;
    end
  end

  assign prediction_o     = pred_q;
  assign predictor_used_o = sel_q;

endmodule

FILE: sv/csp_checker.sv
module csp_checker import csp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [23:0]         m_axis_tdata,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [CfgAddrW-1:0] paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);

  // No output beat survives reset: after an edge in reset the output is empty.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output beat valid during reset");

  // With the output stage empty the whole pipeline can move, so input is ready.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  // A stalled output beat keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // A register read right after a write to it returns the low 16 written bits and zeros above.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready) ##1 (psel && !pwrite && paddr == $past(paddr))
    |-> prdata[15:0] == $past(pwdata[15:0]) && prdata[31:16] == 16'd0)
    else $error("register readback mismatch");

endmodule

bind context_selected_pixel_predictor_core csp_checker u_csp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
